/* rtl/spd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg
// types and constants shared by the peak-hold bar display blocks
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int OP_W         = 2;
  localparam int RSSI_W       = 8;
  localparam int CH_W         = 6;
  localparam int BAR_W        = 6;
  localparam int CHANNELS_DEF = 64;
  localparam int RSSI_FLOOR   = -90;
  localparam int RSSI_CEIL    = -50;

  typedef enum logic [OP_W-1:0] {
    OP_MEASURE = 2'd0,
    OP_READ    = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

/* rtl/spd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_in_if / spd_out_if
// valid/ready channels for command items and bar results
// ----------------------------------------------------------------------------
interface spd_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [7:0] rssi_dbm;
  logic [5:0]        read_index;

  modport source (output valid, output operation, output rssi_dbm, output read_index,
                  input ready);
  modport sink (input valid, input operation, input rssi_dbm, input read_index,
                output ready);
endinterface

interface spd_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] bar_channel;
  logic [5:0] bar_height;
  logic [5:0] next_channel;

  modport source (output valid, output bar_channel, output bar_height, output next_channel,
                  input ready);
  modport sink (input valid, input bar_channel, input bar_height, input next_channel,
                output ready);
endinterface

/* rtl/spd_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_cell
// one bar of the rotating ring, takes its neighbor's bar on shift
// ----------------------------------------------------------------------------
module spd_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  spd_pkg::cell_ctrl_t            ctrl_i,
  input  logic [spd_pkg::BAR_W-1:0]      bar_i,
  output logic [spd_pkg::BAR_W-1:0]      bar_o
);
  import spd_pkg::*;

  logic [BAR_W-1:0] bar_q;
  logic [BAR_W-1:0] bar_d;

  always_comb begin
    bar_d = bar_q;
    if (ctrl_i.clear) begin
      bar_d = '0;
    end else if (ctrl_i.shift) begin
      bar_d = bar_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_q <= '0;
    end else begin
      bar_q <= bar_d;
    end
  end

  assign bar_o = bar_q;

endmodule

/* rtl/spd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_ctrl
// sequencer, head-of-ring update, scan pointer and result register
// ----------------------------------------------------------------------------
module spd_ctrl #(
  parameter int CHANNELS = spd_pkg::CHANNELS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  spd_in_if.sink                     in_i,
  spd_out_if.source                  out_o,
  input  logic [spd_pkg::BAR_W-1:0]  head_bar_i,
  output logic [spd_pkg::BAR_W-1:0]  tail_bar_o,
  output spd_pkg::cell_ctrl_t        cell_ctrl_o
);
  import spd_pkg::*;

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW = (IW > CH_W) ? IW : CH_W;
  localparam logic [IW-1:0] LAST = IW'(CHANNELS - 1);

  state_e           state_q, state_d;
  logic [IW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    ptr_q, ptr_d;
  logic             meas_q, meas_d;
  logic [BAR_W-1:0] h_q, h_d;
  logic [CH_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CH_W-1:0]  res_ch_q, res_ch_d;
  logic [BAR_W-1:0] res_h_q, res_h_d;
  logic             out_valid_q, out_valid_d;
  logic [CH_W-1:0]  out_ch_q, out_ch_d;
  logic [BAR_W-1:0] out_h_q, out_h_d;
  logic [CH_W-1:0]  out_nx_q, out_nx_d;

  logic signed [RSSI_W-1:0] rssi_c;
  logic [BAR_W-1:0]         h_new;
  logic [BAR_W-1:0]         dec;
  logic [BAR_W-1:0]         upd;
  logic [CW-1:0]            cnt_w;
  logic [CW-1:0]            ptr_w;
  logic [CW-1:0]            rd_w;
  logic                     accept;
  logic                     at_ptr;

  // clamp and map strength to height
  always_comb begin
    rssi_c = in_i.rssi_dbm;
    if (in_i.rssi_dbm < RSSI_W'(RSSI_FLOOR)) begin
      rssi_c = RSSI_W'(RSSI_FLOOR);
    end else if (in_i.rssi_dbm > RSSI_W'(RSSI_CEIL)) begin
      rssi_c = RSSI_W'(RSSI_CEIL);
    end
    h_new = BAR_W'(rssi_c - RSSI_W'(RSSI_FLOOR));
  end

  assign cnt_w  = CW'(cnt_q);
  assign ptr_w  = CW'(ptr_q);
  assign rd_w   = CW'(rd_idx_q);
  assign at_ptr = (cnt_q == ptr_q);
  assign accept = in_i.valid && in_i.ready;

  // head of ring: on a measure, decay, then peak hold on the scanned channel
  always_comb begin
    dec = (head_bar_i == '0) ? '0 : head_bar_i - BAR_W'(1);
    upd = head_bar_i;
    if (meas_q) begin
      upd = dec;
      if (at_ptr && (h_q > dec)) begin
        upd = h_q;
      end
    end
  end

  assign tail_bar_o = upd;
  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    meas_d      = meas_q;
    h_d         = h_q;
    rd_idx_d    = rd_idx_q;
    res_ch_d    = res_ch_q;
    res_h_d     = res_h_q;
    out_valid_d = out_valid_q;
    out_ch_d    = out_ch_q;
    out_h_d     = out_h_q;
    out_nx_d    = out_nx_q;
    cell_ctrl_o = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d    = '0;
          h_d      = h_new;
          rd_idx_d = in_i.read_index;
          res_h_d  = '0;
          unique case (op_e'(in_i.operation))
            OP_MEASURE: begin
              meas_d   = 1'b1;
              res_ch_d = ptr_w[CH_W-1:0];
              state_d  = ST_RUN;
            end
            OP_CLEAR: begin
              cell_ctrl_o.clear = 1'b1;
              ptr_d    = '0;
              res_ch_d = '0;
              state_d  = ST_HOLD;
            end
            default: begin
              meas_d   = 1'b0;
              res_ch_d = in_i.read_index;
              state_d  = ST_RUN;
            end
          endcase
        end
      end
      ST_RUN: begin
        cell_ctrl_o.shift = 1'b1;
        cnt_d = cnt_q + IW'(1);
        if (meas_q && at_ptr) begin
          res_h_d = upd;
        end else if (!meas_q && (cnt_w == rd_w)) begin
          res_h_d = head_bar_i;
        end
        if (cnt_q == LAST) begin
          cnt_d   = '0;
          state_d = ST_HOLD;
          if (meas_q) begin
            ptr_d = (ptr_q == LAST) ? '0 : ptr_q + IW'(1);
          end
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_ch_d    = res_ch_q;
          out_h_d     = res_h_q;
          out_nx_d    = ptr_w[CH_W-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      meas_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      meas_q      <= meas_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q      <= h_d;
    rd_idx_q <= rd_idx_d;
    res_ch_q <= res_ch_d;
    res_h_q  <= res_h_d;
    out_ch_q <= out_ch_d;
    out_h_q  <= out_h_d;
    out_nx_q <= out_nx_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.bar_channel  = out_ch_q;
  assign out_o.bar_height   = out_h_q;
  assign out_o.next_channel = out_nx_q;

endmodule

/* rtl/spectrum_peak_hold_decay.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_peak_hold_decay
// peak-hold bar display with decay over a ring of per-channel bar cells
// ----------------------------------------------------------------------------
// The bars sit in a ring of CHANNELS cells that rotates one place per cycle
// while a measure or read runs; every bar passes the head once per such item,
// where decay, the peak update of the scanned channel or the read capture
// happen. After the rotation the sequencer loads the result into the output
// register, waiting while the previous result is still stalled there. A clear
// zeroes every cell at once; the sequencer then steps to its hold state and
// loads the output register. A new item is taken while the previous result
// still waits at the output register.
module spectrum_peak_hold_decay #(
  parameter int CHANNELS = spd_pkg::CHANNELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spd_in_if.sink    in_i,
  spd_out_if.source out_o
);
  import spd_pkg::*;

  cell_ctrl_t       cell_ctrl;
  logic [BAR_W-1:0] ring [CHANNELS];
  logic [BAR_W-1:0] tail_bar;

  spd_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .head_bar_i  (ring[0]),
    .tail_bar_o  (tail_bar),
    .cell_ctrl_o (cell_ctrl)
  );

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    logic [BAR_W-1:0] nb;
    if (i == CHANNELS - 1) begin : g_tail
      assign nb = tail_bar;
    end else begin : g_mid
      assign nb = ring[i+1];
    end
    spd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .bar_i  (nb),
      .bar_o  (ring[i])
    );
  end

endmodule

/* bench/tb_spectrum_peak_hold_decay.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spectrum_peak_hold_decay
// self-checking bench for the peak-hold bar display with decay
// ----------------------------------------------------------------------------
// Drives measure, read, clear and unused-code commands over the input channel
// with random gaps and output stalls. A scoreboard keeps its own bar heights
// and scan pointer, predicts the bar result of every accepted command and
// compares each returned result with the oldest prediction.
module tb_spectrum_peak_hold_decay;
  import spd_pkg::*;

  localparam int          CHANNELS    = CHANNELS_DEF;
  localparam int          CLK_HALF    = 5;
  localparam int          STALL_LIMIT = 2000;
  localparam int          RAND_ITEMS  = 700;
  localparam logic [1:0]  OP_SPARE    = 2'd3;

  typedef struct packed {
    logic [5:0] bar_channel;
    logic [5:0] bar_height;
    logic [5:0] next_channel;
  } bar_result_t;

  class peak_bar_board;
    logic [5:0]  bars [CHANNELS];
    int unsigned scan_ptr;
    bar_result_t pending [$];
    int          mismatches;

    function new();
      foreach (bars[i]) bars[i] = '0;
      scan_ptr   = 0;
      mismatches = 0;
    endfunction

    function void note_command(logic [1:0] op, logic signed [7:0] rssi, logic [5:0] idx);
      bar_result_t res;
      int          level;
      if (op == OP_MEASURE) begin
        foreach (bars[i]) if (bars[i] != 0) bars[i] = bars[i] - 1'b1;
        level = int'(rssi);
        if (level < RSSI_FLOOR) level = RSSI_FLOOR;
        if (level > RSSI_CEIL) level = RSSI_CEIL;
        level = level - RSSI_FLOOR;
        if (level > int'(bars[scan_ptr])) bars[scan_ptr] = level[5:0];
        res.bar_channel = scan_ptr[5:0];
        res.bar_height  = bars[scan_ptr];
        scan_ptr = (scan_ptr + 1 >= CHANNELS) ? 0 : scan_ptr + 1;
      end else if (op == OP_CLEAR) begin
        foreach (bars[i]) bars[i] = '0;
        scan_ptr        = 0;
        res.bar_channel = '0;
        res.bar_height  = '0;
      end else begin
        res.bar_channel = idx;
        res.bar_height  = (int'(idx) < CHANNELS) ? bars[idx] : '0;
      end
      res.next_channel = scan_ptr[5:0];
      pending.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(bar_result_t got);
      bar_result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result ch %0d height %0d next %0d",
                                  got.bar_channel, got.bar_height, got.next_channel));
        return;
      end
      want = pending.pop_front();
      if (got.bar_channel !== want.bar_channel)
        report_mismatch($sformatf("bar_channel %0d, want %0d",
                                  got.bar_channel, want.bar_channel));
      if (got.bar_height !== want.bar_height)
        report_mismatch($sformatf("bar_height %0d, want %0d (ch %0d)",
                                  got.bar_height, want.bar_height, want.bar_channel));
      if (got.next_channel !== want.next_channel)
        report_mismatch($sformatf("next_channel %0d, want %0d",
                                  got.next_channel, want.next_channel));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic steady;
  int   quiet_cycles;

  spd_in_if  in_if ();
  spd_out_if out_if ();

  peak_bar_board board = new();

  spectrum_peak_hold_decay #(
    .CHANNELS(CHANNELS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // command side: random gaps before each transfer unless in the steady stretch
  task automatic send_command(logic [1:0] op, logic signed [7:0] rssi, logic [5:0] idx);
    while (!steady && $urandom_range(99) < 33) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.rssi_dbm   <= rssi;
    in_if.read_index <= idx;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_command(op, rssi, idx);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    int unsigned       pick;
    logic [1:0]        op;
    logic signed [7:0] rssi;
    pick = $urandom_range(99);
    if (pick < 2) op = OP_CLEAR;
    else if (pick < 62) op = OP_MEASURE;
    else if (pick < 92) op = OP_READ;
    else op = OP_SPARE;
    if ($urandom_range(1)) rssi = 8'(-96 + int'($urandom_range(52)));
    else rssi = 8'($urandom_range(255));
    send_command(op, rssi, 6'($urandom_range(63)));
  endtask

  // result side: random stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= steady || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      board.check_result({out_if.bar_channel, out_if.bar_height, out_if.next_channel});
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    steady           = 1'b0;
    quiet_cycles     = 0;
    in_if.valid      = 1'b0;
    in_if.operation  = OP_MEASURE;
    in_if.rssi_dbm   = '0;
    in_if.read_index = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fresh bars, rssi clamp edges, unused code, clear
    send_command(OP_READ, 8'sd0, 6'd0);
    send_command(OP_READ, 8'sd0, 6'd63);
    send_command(OP_MEASURE, -8'sd128, 6'd0);
    send_command(OP_MEASURE, 8'sd127, 6'd0);
    send_command(OP_MEASURE, -8'sd91, 6'd0);
    send_command(OP_MEASURE, -8'sd90, 6'd0);
    send_command(OP_MEASURE, -8'sd89, 6'd0);
    send_command(OP_MEASURE, -8'sd51, 6'd0);
    send_command(OP_MEASURE, -8'sd50, 6'd0);
    send_command(OP_MEASURE, -8'sd49, 6'd0);
    send_command(OP_MEASURE, 8'sd0, 6'd0);
    send_command(OP_MEASURE, -8'sd70, 6'd0);
    send_command(OP_READ, 8'sd0, 6'd1);
    send_command(OP_SPARE, -8'sd1, 6'd9);
    send_command(OP_READ, 8'sd0, 6'd63);
    send_command(OP_CLEAR, 8'sd0, 6'd5);
    send_command(OP_READ, 8'sd0, 6'd1);
    send_command(OP_MEASURE, -8'sd60, 6'd63);
    send_command(OP_SPARE, 8'sd0, 6'd0);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      steady <= (n >= 250 && n < 400);
      send_random();
    end
    in_if.valid <= 1'b0;
    steady      <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (2 * CHANNELS + 8) @(posedge clk_i);

    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
